>>> hw/rtl/knap_pkg.sv
// Shared types and constants for the 0/1 knapsack engine.
package knap_pkg;

    // Field widths
    localparam int CFG_W    = 10;
    localparam int WEIGHT_W = 10;
    localparam int PROFIT_W = 16;
    localparam int VALUE_W  = 32;

    // Default table size and capacity register reset
    localparam int               DEF_MAX_CAPACITY = 1023;
    localparam logic [CFG_W-1:0] CAP_RESET        = 10'd1023;

    // Sequencer states
    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_RUN   = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_READ  = 6'b010000,
        ST_LOAD  = 6'b100000
    } knap_state_t;

    // Table control from the sequencer
    typedef struct packed {
        logic rd_en;     // issue reads on both ports
        logic wr_clear;  // write zero at the sweep address
        logic wr_upd;    // update slot is live, write if the unit says take
        logic load;      // capture the table read into the result register
    } knap_mem_ctl_t;

endpackage

>>> hw/rtl/knap_table.sv
// Best-profit table: one write port, two registered read ports.
module knap_table #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr_a,
    input  logic [AW-1:0]               rd_addr_b,
    output logic [knap_pkg::VALUE_W-1:0] rd_data_a,
    output logic [knap_pkg::VALUE_W-1:0] rd_data_b,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [knap_pkg::VALUE_W-1:0] wr_data
);
    import knap_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rd_a_reg;
    logic [VALUE_W-1:0] rd_b_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read ports, data held while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

>>> hw/rtl/knap_alu.sv
// Shared update unit: saturating profit add and compare against the current entry.
module knap_alu (
    input  logic [knap_pkg::PROFIT_W-1:0] profit,
    input  logic [knap_pkg::VALUE_W-1:0]  entry_cur,   // entry at c
    input  logic [knap_pkg::VALUE_W-1:0]  entry_rem,   // entry at c - weight
    output logic [knap_pkg::VALUE_W-1:0]  taken,
    output logic                          take
);
    import knap_pkg::*;

    logic [VALUE_W:0] sum_wide;

    // Add with carry out, clamp to all ones on overflow
    assign sum_wide = {1'b0, entry_rem} + {{(VALUE_W + 1 - PROFIT_W){1'b0}}, profit};
    assign taken    = sum_wide[VALUE_W] ? {VALUE_W{1'b1}} : sum_wide[VALUE_W-1:0];
    assign take     = taken > entry_cur;

endmodule

>>> hw/rtl/knap_ctrl.sv
// Sequencer: walks the capacities per item, sweeps the table clear, fetches the answer.
module knap_ctrl #(
    parameter int MAX_CAPACITY = 1023,
    parameter int AW           = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [knap_pkg::CFG_W-1:0]    bag_capacity,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [knap_pkg::WEIGHT_W-1:0] item_weight,
    input  logic [knap_pkg::PROFIT_W-1:0] item_profit,
    input  logic                          last_item,
    input  logic                          out_free,
    output knap_pkg::knap_state_t         state,
    output knap_pkg::knap_mem_ctl_t       ctl,
    output logic [AW-1:0]                 rd_addr_a,
    output logic [AW-1:0]                 rd_addr_b,
    output logic [AW-1:0]                 wr_addr,
    output logic [knap_pkg::PROFIT_W-1:0] profit
);
    import knap_pkg::*;

    // Common width for capacity and weight arithmetic
    localparam int            CW        = (AW > CFG_W) ? AW : CFG_W;
    localparam logic [CW-1:0] MAX_CW    = CW'(MAX_CAPACITY);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_CAPACITY);

    knap_state_t         state_reg, state_next;
    logic [AW-1:0]       c_reg, c_next;
    logic [AW-1:0]       low_reg, low_next;
    logic [AW-1:0]       cap_reg, cap_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic [AW-1:0]       p_addr_reg, p_addr_next;
    logic                p_valid_reg, p_valid_next;
    logic                last_reg, last_next;
    logic [WEIGHT_W-1:0] w_reg, w_next;
    logic [PROFIT_W-1:0] profit_reg, profit_next;

    logic          accept;
    logic [CW-1:0] cfg_cw;
    logic [CW-1:0] cap_cw;
    logic [CW-1:0] w_in_cw;
    logic [CW-1:0] low_cw;
    logic          skip;
    logic [CW-1:0] rem_cw;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;

    // Effective capacity and lowest capacity the item touches
    assign cfg_cw  = CW'(bag_capacity);
    assign cap_cw  = (cfg_cw > MAX_CW) ? MAX_CW : cfg_cw;
    assign w_in_cw = CW'(item_weight);
    assign low_cw  = (w_in_cw > CW'(1)) ? w_in_cw : CW'(1);
    assign skip    = low_cw > cap_cw;

    // Remaining-capacity address for the current step
    assign rem_cw = CW'(c_reg) - CW'(w_reg);

    always_comb
    begin
        state_next   = state_reg;
        c_next       = c_reg;
        low_next     = low_reg;
        cap_next     = cap_reg;
        clr_next     = clr_reg;
        last_next    = last_reg;
        w_next       = w_reg;
        profit_next  = profit_reg;
        p_valid_next = 1'b0;
        p_addr_next  = c_reg;
        ctl          = '0;
        rd_addr_a    = c_reg;
        rd_addr_b    = c_reg;
        wr_addr      = p_addr_reg;
        ctl.wr_upd   = p_valid_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ctl.wr_clear = 1'b1;
                wr_addr      = clr_reg;
                clr_next     = clr_reg + AW'(1);
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cap_next    = cap_cw[AW-1:0];
                    c_next      = cap_cw[AW-1:0];
                    low_next    = low_cw[AW-1:0];
                    w_next      = item_weight;
                    profit_next = item_profit;
                    last_next   = last_item;
                    if (!skip)
                    begin
                        state_next = ST_RUN;
                    end
                    else if (last_item)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_RUN:
            begin
                // One capacity per cycle, highest first
                ctl.rd_en    = 1'b1;
                rd_addr_b    = rem_cw[AW-1:0];
                p_valid_next = 1'b1;
                if (c_reg == low_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    c_next = c_reg - AW'(1);
                end
            end
            ST_DRAIN:
            begin
                // Final update write lands this cycle
                state_next = last_reg ? ST_READ : ST_IDLE;
            end
            ST_READ:
            begin
                ctl.rd_en  = 1'b1;
                rd_addr_a  = cap_reg;
                rd_addr_b  = cap_reg;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    ctl.load   = 1'b1;
                    clr_next   = '0;
                    state_next = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            p_valid_reg <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            p_valid_reg <= p_valid_next;
            last_reg    <= last_next;
        end
    end

    // Item and walk payload
    always_ff @(posedge clk)
    begin
        c_reg      <= c_next;
        low_reg    <= low_next;
        cap_reg    <= cap_next;
        w_reg      <= w_next;
        profit_reg <= profit_next;
        p_addr_reg <= p_addr_next;
    end

    assign state  = state_reg;
    assign profit = profit_reg;

endmodule

>>> hw/rtl/zero_one_knapsack_engine.sv
// Top level of the 0/1 knapsack engine: config register, table, update unit, result register.
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  ------------------------------------
//  config   in         cfg_wen                   cfg_wdata (bag_capacity)
//  item     in         item_valid / item_stall   item_weight, item_profit, last_item
//  result   out        result_valid / result_stall  best_profit
//
// An item beat walks n = cap - max(weight,1) + 1 capacities one per cycle through
// the single update unit and table port pair (n = 0 when the item is heavier than
// the capacity). A last item then reads the answer and runs a clearing pass over
// every table entry. After reset the same clearing pass runs with item_stall high.
// A stalled result holds in its register; the next last item waits only at answer load.
module zero_one_knapsack_engine #(
    parameter int MAX_CAPACITY = knap_pkg::DEF_MAX_CAPACITY
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic [knap_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic [knap_pkg::WEIGHT_W-1:0] item_weight,
    input  logic [knap_pkg::PROFIT_W-1:0] item_profit,
    input  logic                          last_item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [knap_pkg::VALUE_W-1:0]  best_profit
);
    import knap_pkg::*;

    localparam int DEPTH = MAX_CAPACITY + 1;
    localparam int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;

    logic [CFG_W-1:0]   cap_reg;
    logic               result_valid_reg;
    logic [VALUE_W-1:0] best_profit_reg;

    knap_state_t        state;
    knap_mem_ctl_t      ctl;
    logic [AW-1:0]      rd_addr_a;
    logic [AW-1:0]      rd_addr_b;
    logic [AW-1:0]      wr_addr;
    logic [PROFIT_W-1:0] profit;
    logic [VALUE_W-1:0] rd_data_a;
    logic [VALUE_W-1:0] rd_data_b;
    logic [VALUE_W-1:0] taken;
    logic               take;
    logic               wr_en;
    logic [VALUE_W-1:0] wr_data;
    logic               out_free;

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wen)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    knap_ctrl #(
        .MAX_CAPACITY (MAX_CAPACITY),
        .AW           (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .bag_capacity (cap_reg),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_weight  (item_weight),
        .item_profit  (item_profit),
        .last_item    (last_item),
        .out_free     (out_free),
        .state        (state),
        .ctl          (ctl),
        .rd_addr_a    (rd_addr_a),
        .rd_addr_b    (rd_addr_b),
        .wr_addr      (wr_addr),
        .profit       (profit)
    );

    knap_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .clk       (clk),
        .rd_en     (ctl.rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    knap_alu u_alu (
        .profit    (profit),
        .entry_cur (rd_data_a),
        .entry_rem (rd_data_b),
        .taken     (taken),
        .take      (take)
    );

    // Table write: clearing sweep or improved entry
    assign wr_en   = ctl.wr_clear || (ctl.wr_upd && take);
    assign wr_data = ctl.wr_clear ? '0 : taken;

    // Result register
    assign out_free = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            best_profit_reg <= rd_data_a;
        end
    end

    assign result_valid = result_valid_reg;
    assign best_profit  = best_profit_reg;

    // No table write while waiting for an item
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state == ST_IDLE) |-> !wr_en)
        else $error("table written while idle");

    // A result appears only after the answer load
    a_result_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state == ST_LOAD))
        else $error("result raised outside answer load");

    // Walk reads never look above the entry being updated
    a_rem_below_cur: assert property (@(posedge clk) disable iff (!rst_n)
        (state == ST_RUN) |-> (rd_addr_b <= rd_addr_a))
        else $error("remaining-capacity address above current address");

    // Answer load never overwrites a pending result
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |-> (!result_valid_reg || !result_stall))
        else $error("answer loaded over a stalled result");

endmodule

>>> tb/sv/zero_one_knapsack_engine_tb.sv
// Self-checking bench for the 0/1 knapsack engine: predicted best profits against the result port.
`timescale 1ns / 100ps

module zero_one_knapsack_engine_tb;

    import knap_pkg::*;

    localparam int MAX_CAP       = DEF_MAX_CAPACITY;
    // longest walk of one item plus a clearing pass, with margin
    localparam int SETTLE_CYCLES = 2 * (MAX_CAP + 1) + 64;
    localparam int LIMIT_CYCLES  = 8_000_000;
    localparam int RANDOM_ITEMS  = 580;
    localparam int IDLE_PCT      = 17;
    localparam int MAX_REPORTS   = 50;

    // Scoreboard: best profit per capacity, and the answers still owed by the block
    class best_profit_book;
        logic [VALUE_W-1:0] best_at [MAX_CAP+1];
        logic [CFG_W-1:0]   capacity;
        logic [VALUE_W-1:0] owed [$];
        int                 items;
        int                 answers;
        int                 errors;

        function new();
            foreach (best_at[i])
                best_at[i] = '0;
            capacity = CAP_RESET;
            items    = 0;
            answers  = 0;
            errors   = 0;
        endfunction

        function void set_capacity(logic [CFG_W-1:0] v);
            capacity = v;
        endfunction

        // Fold one accepted item into the table; a last item owes an answer and clears
        function void note_item(logic [WEIGHT_W-1:0] w, logic [PROFIT_W-1:0] p, logic last);
            int           cap;
            int           low;
            int           c;
            logic [VALUE_W:0] sum;
            cap = int'(capacity);
            if (cap > MAX_CAP)
                cap = MAX_CAP;
            low = (int'(w) > 1) ? int'(w) : 1;
            // downward walk keeps each item used at most once
            for (c = cap; c >= low; c--)
            begin
                sum = {1'b0, best_at[c - int'(w)]} + p;
                if (sum[VALUE_W])
                    sum[VALUE_W-1:0] = '1;
                if (sum[VALUE_W-1:0] > best_at[c])
                    best_at[c] = sum[VALUE_W-1:0];
            end
            items++;
            if (last)
            begin
                owed = {owed, best_at[cap]};
                foreach (best_at[i])
                    best_at[i] = '0;
            end
        endfunction

        // Compare one result beat with the oldest owed answer
        function void check_best(logic [VALUE_W-1:0] got);
            logic [VALUE_W-1:0] want;
            if (owed.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: best_profit beat with none owed, expected none, actual %0d",
                             $time, got);
                return;
            end
            want = owed.pop_front();
            answers++;
            if (got !== want)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: best_profit expected %0d, actual %0d", $time, want, got);
            end
        endfunction
    endclass

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                cfg_wen      = 1'b0;
    logic [CFG_W-1:0]    cfg_wdata    = '0;
    logic                item_valid   = 1'b0;
    logic                item_stall;
    logic [WEIGHT_W-1:0] item_weight  = '0;
    logic [PROFIT_W-1:0] item_profit  = '0;
    logic                last_item    = 1'b0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [VALUE_W-1:0]  best_profit;

    best_profit_book book;
    bit              calm      = 1'b0;
    int              cycles    = 0;
    int              cap_writes = 0;

    zero_one_knapsack_engine #(
        .MAX_CAPACITY (MAX_CAP)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_weight  (item_weight),
        .item_profit  (item_profit),
        .last_item    (last_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .best_profit  (best_profit)
    );

    always #10 clk = ~clk;

    // Cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("%0t: timed out after %0d cycles", $time, cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
        result_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);

    // Result beats are sampled mid-cycle, where nothing is moving
    always @(negedge clk)
        if (rst_n && result_valid && !result_stall)
            book.check_best(best_profit);

    // Present one item beat, with a random gap first outside calm phases; returns at the accepting edge
    task automatic send_item(input logic [WEIGHT_W-1:0] w, input logic [PROFIT_W-1:0] p,
                             input logic last);
        bit taken;
        if (!calm)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
            end
        end
        item_valid  <= 1'b1;
        item_weight <= w;
        item_profit <= p;
        last_item   <= last;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !item_stall;
            @(posedge clk);
        end
        book.note_item(w, p, last);
    endtask

    // Hold off the sender until every owed answer is in and the block has settled
    task automatic drain_results();
        item_valid <= 1'b0;
        while (book.owed.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] v);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_wen <= 1'b0;
        book.set_capacity(v);
        cap_writes++;
    endtask

    initial
    begin
        int                  cap;
        int                  heavy;
        int                  n;
        int                  i;
        int                  sent;
        int                  phase;
        logic [WEIGHT_W-1:0] w;
        logic [PROFIT_W-1:0] p;
        logic                l;

        book = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full capacity: heaviest item, zero-weight item, zero and max profit
        write_capacity(10'd1023);
        send_item(10'd1023, 16'hFFFF, 1'b0);
        send_item(10'd0, 16'd1, 1'b0);
        send_item(10'd1, 16'd0, 1'b1);
        send_item(10'd1, 16'hFFFF, 1'b1);
        drain_results();

        // Zero capacity: nothing fits, entry zero stays zero
        write_capacity(10'd0);
        send_item(10'd0, 16'hFFFF, 1'b1);
        send_item(10'd5, 16'd7, 1'b1);
        send_item(10'd1023, 16'd0, 1'b1);
        drain_results();

        // Small bag with an item heavier than the bag, then a set left open
        write_capacity(10'd10);
        send_item(10'd11, 16'd100, 1'b0);
        send_item(10'd10, 16'd50, 1'b0);
        send_item(10'd3, 16'd20, 1'b0);
        send_item(10'd7, 16'd40, 1'b1);
        send_item(10'd4, 16'd10, 1'b0);
        drain_results();

        // Capacity shrinks inside the open set
        write_capacity(10'd5);
        send_item(10'd1, 16'd5, 1'b0);
        send_item(10'd0, 16'd3, 1'b0);
        drain_results();

        // ... and grows again before the answer
        write_capacity(10'd1023);
        send_item(10'd2, 16'd3, 1'b1);
        drain_results();

        // Random sets, each phase under its own capacity
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            calm = (phase == 2 || phase == 3);
            case ($urandom_range(0, 9))
                0:       cap = MAX_CAP;
                1:       cap = 0;
                2:       cap = $urandom_range(0, 1023);
                default: cap = $urandom_range(1, 48);
            endcase
            write_capacity(cap[CFG_W-1:0]);
            n = (cap > 64) ? $urandom_range(3, 6) : $urandom_range(15, 35);
            for (i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 9))
                    0: w = '0;
                    1: w = WEIGHT_W'($urandom_range(0, 1023));
                    2:
                    begin
                        heavy = cap + 1 + $urandom_range(0, 8);
                        w = (heavy > 1023) ? 10'd1023 : heavy[WEIGHT_W-1:0];
                    end
                    default: w = WEIGHT_W'($urandom_range(1, (cap > 0) ? cap : 1));
                endcase
                case ($urandom_range(0, 7))
                    0:       p = '0;
                    1:       p = '1;
                    default: p = PROFIT_W'($urandom_range(0, 65535));
                endcase
                l = ($urandom_range(0, 4) == 0);
                // most phases close their set, a few leave it open across the write
                if (i == n - 1)
                    l = ($urandom_range(0, 3) != 0);
                send_item(w, p, l);
                sent++;
            end
            drain_results();
            phase++;
        end
        calm = 1'b0;

        $display("checked %0d answers from %0d items under %0d capacity writes",
                 book.answers, book.items, cap_writes);
        $display("run took in heavy and zero weights, zero and full bags, open sets across writes");
        if (book.errors == 0 && book.owed.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
